/* hdl/srfm_pkg.sv */
`timescale 1ns / 1ps
// Package for the stereo RMS frame meter: field widths, state encodings
// and the command bundle from the frame controller to the channel lanes.
// No dependencies.
package srfm_pkg;

  localparam int RAW_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int SHIFT    = 11;
  localparam int SQ_W     = 32;
  localparam int ROOT_W   = 16;
  localparam int FLEN_W   = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MR_IDLE,
    MR_DIV,
    MR_ROOT
  } mr_phase_t;

  typedef struct packed {
    logic take;
    logic square;
    logic accum;
    logic close;
  } lane_cmd_t;

endpackage

/* hdl/srfm_mean_root.sv */
`timescale 1ns / 1ps
// Iterative mean and root unit: restoring divide of the square sum by the
// frame length (one quotient bit per cycle), then a digit-by-digit integer
// square root (one root bit per cycle). Depends on srfm_pkg.
module srfm_mean_root #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [SUM_W-1:0]            sum,
  input  logic [CNT_W-1:0]            count,
  output logic [srfm_pkg::ROOT_W-1:0] root,
  output logic                        done
);

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int SR_W   = srfm_pkg::ROOT_W + 3;

  srfm_pkg::mr_phase_t phase_r, phase_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [SUM_W-1:0]            dq_r, dq_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]            div_r, div_nxt;
  logic [31:0]                 v_r, v_nxt;
  logic [SR_W-1:0]             srem_r, srem_nxt;
  logic [srfm_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic                        done_r, done_nxt;

  logic [CNT_W:0]      rem_sh, rem_sub;
  logic                ge;
  logic [SUM_W+31:0]   q_ext;
  logic [SR_W-1:0]     s_sh, s_trial, s_sub;
  logic                s_ge;

  always_comb begin
    rem_sh  = {rem_r, dq_r[SUM_W-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
    q_ext   = {32'd0, dq_r[SUM_W-2:0], ge};
    s_sh    = {srem_r[SR_W-3:0], v_r[31:30]};
    s_trial = {1'b0, root_r, 2'b01};
    s_ge    = s_sh >= s_trial;
    s_sub   = s_sh - s_trial;

    phase_nxt = phase_r;
    step_nxt  = step_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    v_nxt     = v_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    done_nxt  = done_r;

    unique case (phase_r)
      srfm_pkg::MR_IDLE: begin
        if (start) begin
          dq_nxt    = sum;
          div_nxt   = count;
          rem_nxt   = '0;
          step_nxt  = '0;
          done_nxt  = 1'b0;
          phase_nxt = srfm_pkg::MR_DIV;
        end
      end
      srfm_pkg::MR_DIV: begin
        rem_nxt  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq_nxt   = {dq_r[SUM_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          v_nxt     = q_ext[31:0];
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          phase_nxt = srfm_pkg::MR_ROOT;
        end
      end
      srfm_pkg::MR_ROOT: begin
        v_nxt    = {v_r[29:0], 2'b00};
        srem_nxt = s_ge ? s_sub : s_sh;
        root_nxt = {root_r[srfm_pkg::ROOT_W-2:0], s_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(srfm_pkg::ROOT_W - 1)) begin
          done_nxt  = 1'b1;
          phase_nxt = srfm_pkg::MR_IDLE;
        end
      end
      default: begin
        phase_nxt = srfm_pkg::MR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srfm_pkg::MR_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    v_r    <= v_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* hdl/srfm_lane.sv */
`timescale 1ns / 1ps
// One channel lane: sample conversion, squaring, square-sum accumulation
// and the per-frame mean/root unit. Depends on srfm_pkg, srfm_mean_root.
module srfm_lane #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srfm_pkg::lane_cmd_t                 cmd,
  input  logic [srfm_pkg::RAW_W-1:0]          raw,
  input  logic [CNT_W-1:0]                    count,
  output logic signed [srfm_pkg::SAMPLE_W-1:0] sample,
  output logic [srfm_pkg::ROOT_W-1:0]         rms,
  output logic                                done
);

  logic signed [srfm_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [srfm_pkg::SQ_W-1:0]     prod;
  logic [srfm_pkg::SQ_W-1:0]            sq_r;
  logic [SUM_W-1:0]                     sum_r, sum_nxt, sum_add;
  logic [SUM_W+srfm_pkg::SQ_W-1:0]      sq_ext;

  assign prod    = sample_r * sample_r;
  assign sq_ext  = {{SUM_W{1'b0}}, sq_r};
  assign sum_add = sum_r + sq_ext[SUM_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    if (cmd.accum) begin
      sum_nxt = cmd.close ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r <= raw[srfm_pkg::SHIFT+srfm_pkg::SAMPLE_W-1:srfm_pkg::SHIFT];
    end
    if (cmd.square) begin
      sq_r <= prod;
    end
  end

  srfm_mean_root #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_mean_root (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.accum && cmd.close),
    .sum  (sum_add),
    .count(count),
    .root (rms),
    .done (done)
  );

  assign sample = sample_r;

endmodule

/* hdl/stereo_rms_frame_meter.sv */
`timescale 1ns / 1ps
// Stereo RMS frame meter, top level. Depends on srfm_pkg and srfm_lane.
// Each input transfer carries one stereo frame of two raw 32-bit I2S words;
// each word becomes a 16-bit sample (bits 26..11) and one output transfer
// follows per input. Two lanes, one per channel, square and accumulate;
// when a frame closes (tlast, or MAX_FRAMES items) each lane divides its
// square sum by the frame length and takes the floor square root, and the
// merge stage packs both levels with the length. An item that does not
// close a frame passes through accept, square, accumulate and output. A
// closing item also waits, before output, for the bit-serial divider and
// root unit in each lane; the square sum is SUM_W = 31 + clog2(MAX_FRAMES)
// bits wide. The output register holds a result while the next input
// transfer is taken.
module stereo_rms_frame_meter #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_left[31:0], raw_right[63:32]
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_sample[15:0], right_sample[31:16], rms_left[47:32],
  // rms_right[63:48], frame_length[74:64], zero[79:75]
  output logic [79:0] out_tdata,
  output logic        out_tlast   // level_valid
);

  localparam int SUM_W = 31 + $clog2(MAX_FRAMES);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  srfm_pkg::state_t    state_r, state_nxt;
  srfm_pkg::lane_cmd_t cmd;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W:0]      cnt_inc;
  logic [CNT_W+10:0]   flen_ext;
  logic                hit, last;
  logic                last_r, close_r;
  logic [srfm_pkg::FLEN_W-1:0] flen_r;
  logic                load_out;
  logic                out_valid_r;
  logic [79:0]         out_data_r;
  logic                out_last_r;

  logic signed [srfm_pkg::SAMPLE_W-1:0] smp_l, smp_r;
  logic [srfm_pkg::ROOT_W-1:0]          rms_l, rms_r;
  logic                                 done_l, done_r;

  assign cnt_inc  = {1'b0, count_r} + 1'b1;
  assign hit      = cnt_inc >= (CNT_W + 1)'(MAX_FRAMES);
  assign last     = last_r || hit;
  assign flen_ext = {11'd0, cnt_inc[CNT_W-1:0]};
  assign load_out = (state_r == srfm_pkg::ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cmd        = '0;
    in_tready  = 1'b0;

    unique case (state_r)
      srfm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = srfm_pkg::ST_SQUARE;
        end
      end
      srfm_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = srfm_pkg::ST_ACCUM;
      end
      srfm_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
        cmd.close = last;
        count_nxt = last ? '0 : cnt_inc[CNT_W-1:0];
        state_nxt = last ? srfm_pkg::ST_ROOT : srfm_pkg::ST_DONE;
      end
      srfm_pkg::ST_ROOT: begin
        if (done_l && done_r) begin
          state_nxt = srfm_pkg::ST_DONE;
        end
      end
      srfm_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = srfm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srfm_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_r <= in_tlast;
    end
    if (cmd.accum) begin
      close_r <= last;
      flen_r  <= flen_ext[srfm_pkg::FLEN_W-1:0];
    end
    if (load_out) begin
      out_last_r <= close_r;
      out_data_r <= {5'd0,
                     close_r ? flen_r : '0,
                     close_r ? rms_r : '0,
                     close_r ? rms_l : '0,
                     smp_r, smp_l};
    end
  end

  srfm_lane #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .raw   (in_tdata[31:0]),
    .count (cnt_inc[CNT_W-1:0]),
    .sample(smp_l),
    .rms   (rms_l),
    .done  (done_l)
  );

  srfm_lane #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .raw   (in_tdata[63:32]),
    .count (cnt_inc[CNT_W-1:0]),
    .sample(smp_r),
    .rms   (rms_r),
    .done  (done_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* hdl/srfm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the stereo RMS frame meter and its bind.
// Depends on stereo_rms_frame_meter only through its ports.
module srfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

  a_open_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[79:32] == 48'd0)
    else $error("levels reported on an item that did not close a frame");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[47:32] <= 16'h8000 && out_tdata[63:48] <= 16'h8000)
    else $error("level above full scale");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item in progress");

endmodule

bind stereo_rms_frame_meter srfm_checker u_srfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
